### hdl/bec_pkg.sv
// bec_pkg: shared types, codes and the divider step for barycentric_edge_crossing
// no dependencies
`default_nettype none
package bec_pkg;

    localparam int FRAC_BITS_DEF = 24;

    // status codes
    localparam logic [1:0] ST_CROSS  = 2'd0;
    localparam logic [1:0] ST_INSIDE = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    // edge codes
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    // lane codes
    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    // one divider lane in flight
    typedef struct packed {
        logic [31:0] nm;      // |pos|
        logic [31:0] dm;      // |disp|
        logic [32:0] rem;
        logic [32:0] quo;
        logic        ovf;     // quotient ran past 33 bits
        logic        neg;     // result is negative
        logic        num_pos; // pos >= 0, zero divisor saturates high
        logic        nzero;   // pos == 0
        logic        dzero;   // disp == 0
    } lane_t;

    // decision carried next to the lanes
    typedef struct packed {
        logic       fixed;    // fraction does not come from a quotient
        logic       frac_one; // fixed fraction is 1.0, else 0
        logic       two;      // pick the nearer of two lanes
        logic [1:0] l1;
        logic [1:0] l2;
        logic [1:0] edge_sel;
        logic [1:0] status;
    } ctl_t;

    // one restoring division step
    function automatic lane_t div_step(lane_t s, logic nbit);
        lane_t      o;
        logic [32:0] rem2;
        logic        ge;
        o    = s;
        rem2 = {s.rem[31:0], nbit};
        ge   = rem2 >= {1'b0, s.dm};
        o.rem = ge ? (rem2 - {1'b0, s.dm}) : rem2;
        o.quo = {s.quo[31:0], ge};
        o.ovf = s.ovf | s.quo[32];
        return o;
    endfunction

    // edge crossed when the given coordinate goes negative
    function automatic logic [1:0] lane_edge(logic [1:0] lane);
        logic [1:0] e;
        unique case (lane)
            LANE_A:  e = EDGE_BC;
            LANE_B:  e = EDGE_CA;
            default: e = EDGE_AB;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

### hdl/barycentric_edge_crossing.sv
// barycentric_edge_crossing: edge exit of a barycentric move, fully pipelined
// depends on bec_pkg
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, pos_*, disp_*          | request in
//  out     | out_valid/out_ready, edge_index, crossing_fraction, status | request out
//  cfg     | cfg_we, cfg_data (snap_threshold)         | write only
//
// FRAC_BITS+35 register stages: one classify stage, 32+FRAC_BITS restoring
// divider stages (three lanes side by side), a saturate stage and an output stage.
// one request enters every cycle; the whole pipe holds while the output waits.
// rst_n clears the valid bits and sets snap_threshold to 1.
`default_nettype none
module barycentric_edge_crossing #(
    parameter int FRAC_BITS = bec_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] pos_a,
    input  wire logic signed [31:0] pos_b,
    input  wire logic signed [31:0] pos_c,
    input  wire logic signed [31:0] disp_a,
    input  wire logic signed [31:0] disp_b,
    input  wire logic signed [31:0] disp_c,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              edge_index,
    output logic signed [31:0]      crossing_fraction,
    output logic [1:0]              status
);

    localparam int N = 32 + FRAC_BITS;
    localparam logic [31:0] FRAC_ONE =
        (FRAC_BITS >= 31) ? 32'h7fffffff : 32'(64'd1 << FRAC_BITS);

    logic [15:0] thr_reg;
    logic        adv;

    bec_pkg::lane_t lane_reg [0:N][0:2];
    bec_pkg::ctl_t  ctl_reg  [0:N];
    logic           vld_reg  [0:N];

    logic signed [31:0] qs_reg [0:2];
    logic signed [31:0] qs_next [0:2];
    bec_pkg::ctl_t      ctl_s_reg;
    logic               vld_s_reg;

    logic               out_valid_reg;
    logic [1:0]         edge_reg, edge_next;
    logic signed [31:0] frac_reg, frac_next;
    logic [1:0]         status_reg;

    // whole pipe moves when the output slot is free
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // snap threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // classify: end point, snapping, sign pattern
    logic signed [31:0] pos_v [0:2];
    logic signed [31:0] disp_v [0:2];
    logic               zr [0:2];
    logic               ng [0:2];
    bec_pkg::lane_t     lane_next [0:2];
    bec_pkg::ctl_t      ctl_next;

    assign pos_v[0]  = pos_a;
    assign pos_v[1]  = pos_b;
    assign pos_v[2]  = pos_c;
    assign disp_v[0] = disp_a;
    assign disp_v[1] = disp_b;
    assign disp_v[2] = disp_c;

    always_comb
    begin
        logic signed [32:0] e;
        logic [32:0]        mag;
        logic [1:0]         negs;
        for (int k = 0; k < 3; k++)
        begin
            e   = 33'(pos_v[k]) + 33'(disp_v[k]);
            mag = e[32] ? 33'(-e) : 33'(e);
            zr[k] = (mag < {17'd0, thr_reg}) || (e == '0);
            ng[k] = !zr[k] && e[32];
            lane_next[k].nm      = pos_v[k][31] ? 32'(-pos_v[k]) : 32'(pos_v[k]);
            lane_next[k].dm      = disp_v[k][31] ? 32'(-disp_v[k]) : 32'(disp_v[k]);
            lane_next[k].rem     = '0;
            lane_next[k].quo     = '0;
            lane_next[k].ovf     = 1'b0;
            lane_next[k].num_pos = !pos_v[k][31];
            lane_next[k].nzero   = (pos_v[k] == '0);
            lane_next[k].dzero   = (disp_v[k] == '0);
            // -pos/disp is negative when pos and disp share a sign
            lane_next[k].neg     = pos_v[k][31] == disp_v[k][31];
        end
        negs = 2'(ng[0]) + 2'(ng[1]) + 2'(ng[2]);

        ctl_next.fixed    = 1'b1;
        ctl_next.frac_one = 1'b0;
        ctl_next.two      = 1'b0;
        ctl_next.l1       = bec_pkg::LANE_A;
        ctl_next.l2       = bec_pkg::LANE_A;
        ctl_next.edge_sel = bec_pkg::EDGE_AB;
        ctl_next.status   = bec_pkg::ST_CROSS;
        if (zr[0] || zr[1] || zr[2])
        begin
            ctl_next.frac_one = 1'b1;
            ctl_next.edge_sel = zr[0] ? bec_pkg::EDGE_BC
                              : zr[1] ? bec_pkg::EDGE_CA : bec_pkg::EDGE_AB;
        end
        else if (negs == 2'd0)
        begin
            ctl_next.status = bec_pkg::ST_INSIDE;
        end
        else if (negs == 2'd3)
        begin
            ctl_next.status = bec_pkg::ST_BAD;
        end
        else if (negs == 2'd1)
        begin
            ctl_next.fixed = 1'b0;
            ctl_next.l1 = ng[0] ? bec_pkg::LANE_A : ng[1] ? bec_pkg::LANE_B : bec_pkg::LANE_C;
        end
        else
        begin
            // the second lane (l2) wins only when strictly nearer
            ctl_next.fixed = 1'b0;
            ctl_next.two   = 1'b1;
            if (!ng[0])
            begin
                ctl_next.l1 = bec_pkg::LANE_C;
                ctl_next.l2 = bec_pkg::LANE_B;
            end
            else if (!ng[1])
            begin
                ctl_next.l1 = bec_pkg::LANE_A;
                ctl_next.l2 = bec_pkg::LANE_C;
            end
            else
            begin
                ctl_next.l1 = bec_pkg::LANE_B;
                ctl_next.l2 = bec_pkg::LANE_A;
            end
        end
    end

    // stage 0 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_next;
            for (int k = 0; k < 3; k++)
            begin
                lane_reg[0][k] <= lane_next[k];
            end
        end
    end

    // divider stages, one quotient bit each
    for (genvar j = 0; j < N; j++)
    begin : g_div
        logic nbit;
        if (j < 32)
        begin : g_num
            assign nbit = 1'b0;
        end
        else
        begin : g_pad
            assign nbit = 1'b0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctl_reg[j+1] <= ctl_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    if (j < 32)
                    begin
                        lane_reg[j+1][k] <= bec_pkg::div_step(lane_reg[j][k],
                            lane_reg[j][k].nm[31 - (j % 32)] | nbit);
                    end
                    else
                    begin
                        lane_reg[j+1][k] <= bec_pkg::div_step(lane_reg[j][k], nbit);
                    end
                end
            end
        end
    end

    // sign and saturation per lane
    always_comb
    begin
        bec_pkg::lane_t s;
        for (int k = 0; k < 3; k++)
        begin
            s = lane_reg[N][k];
            if (s.nzero)
            begin
                qs_next[k] = '0;
            end
            else if (s.dzero)
            begin
                qs_next[k] = s.num_pos ? bec_pkg::SAT_MAX : bec_pkg::SAT_MIN;
            end
            else if (s.neg)
            begin
                qs_next[k] = (s.ovf || s.quo > 33'h080000000) ? bec_pkg::SAT_MIN
                           : 32'(~s.quo + 33'd1);
            end
            else
            begin
                qs_next[k] = (s.ovf || s.quo > 33'h07fffffff) ? bec_pkg::SAT_MAX
                           : 32'(s.quo);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_s_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_s_reg <= ctl_reg[N];
            for (int k = 0; k < 3; k++)
            begin
                qs_reg[k] <= qs_next[k];
            end
        end
    end

    // final pick of edge and fraction
    always_comb
    begin
        logic signed [31:0] q1, q2;
        q1 = qs_reg[ctl_s_reg.l1];
        q2 = qs_reg[ctl_s_reg.l2];
        if (ctl_s_reg.fixed)
        begin
            edge_next = ctl_s_reg.edge_sel;
            frac_next = ctl_s_reg.frac_one ? FRAC_ONE : '0;
        end
        else if (ctl_s_reg.two && (q1 > q2))
        begin
            edge_next = bec_pkg::lane_edge(ctl_s_reg.l2);
            frac_next = q2;
        end
        else
        begin
            edge_next = bec_pkg::lane_edge(ctl_s_reg.l1);
            frac_next = q1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            edge_reg   <= edge_next;
            frac_reg   <= frac_next;
            status_reg <= ctl_s_reg.status;
        end
    end

    assign out_valid         = out_valid_reg;
    assign edge_index        = edge_reg;
    assign crossing_fraction = frac_reg;
    assign status            = status_reg;

    // checks
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready does not follow output slot");
    a_nocross: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bec_pkg::ST_CROSS |->
            crossing_fraction == '0 && edge_index == bec_pkg::EDGE_AB)
        else $error("non-crossing result carries data");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3 && edge_index != 2'd3)
        else $error("invalid code on output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(crossing_fraction))
        else $error("stalled result changed");

endmodule
`default_nettype wire
